// ===== src/quadratic_bezier_tessellator_unit_assert.svh =====
// assertion macros for the bezier tessellator
`ifndef QUADRATIC_BEZIER_TESSELLATOR_UNIT_ASSERT_SVH
`define QUADRATIC_BEZIER_TESSELLATOR_UNIT_ASSERT_SVH

// same-cycle implication, checked on every clock outside reset
`define QBT_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every clock outside reset
`define QBT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/qbt_pkg.sv =====
// types, constants and cosine table for the bezier tessellator
package qbt_pkg;

    localparam int COORD_W    = 32;
    localparam int COLOUR_W   = 32;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 4;
    localparam int TAB_IDX_W  = 6;
    localparam int QUO_W      = 32;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] ctrl_x;
        logic signed [COORD_W-1:0] ctrl_y;
        logic [COLOUR_W-1:0]       start_colour;
        logic [COLOUR_W-1:0]       end_colour;
    } qbt_seg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [COLOUR_W-1:0]       point_colour;
        logic                      is_last;
    } qbt_point_t;

    // cos(k*pi/100) in q2.15 (17-bit signed)
    function automatic logic signed [16:0] cos_q15(input logic [TAB_IDX_W-1:0] k);
        logic signed [16:0] c;
        case (k)
            6'd0:  c = 17'sd32768;
            6'd1:  c = 17'sd32752;
            6'd2:  c = 17'sd32703;
            6'd3:  c = 17'sd32623;
            6'd4:  c = 17'sd32510;
            6'd5:  c = 17'sd32365;
            6'd6:  c = 17'sd32188;
            6'd7:  c = 17'sd31979;
            6'd8:  c = 17'sd31739;
            6'd9:  c = 17'sd31467;
            6'd10: c = 17'sd31164;
            6'd11: c = 17'sd30831;
            6'd12: c = 17'sd30467;
            6'd13: c = 17'sd30073;
            6'd14: c = 17'sd29649;
            6'd15: c = 17'sd29197;
            6'd16: c = 17'sd28715;
            6'd17: c = 17'sd28205;
            6'd18: c = 17'sd27667;
            6'd19: c = 17'sd27102;
            6'd20: c = 17'sd26510;
            6'd21: c = 17'sd25892;
            6'd22: c = 17'sd25248;
            6'd23: c = 17'sd24580;
            6'd24: c = 17'sd23887;
            6'd25: c = 17'sd23170;
            6'd26: c = 17'sd22431;
            6'd27: c = 17'sd21670;
            6'd28: c = 17'sd20887;
            6'd29: c = 17'sd20084;
            6'd30: c = 17'sd19261;
            6'd31: c = 17'sd18418;
            6'd32: c = 17'sd17558;
            6'd33: c = 17'sd16680;
            6'd34: c = 17'sd15786;
            6'd35: c = 17'sd14876;
            6'd36: c = 17'sd13952;
            6'd37: c = 17'sd13014;
            6'd38: c = 17'sd12063;
            6'd39: c = 17'sd11100;
            6'd40: c = 17'sd10126;
            6'd41: c = 17'sd9142;
            6'd42: c = 17'sd8149;
            6'd43: c = 17'sd7148;
            6'd44: c = 17'sd6140;
            6'd45: c = 17'sd5126;
            6'd46: c = 17'sd4107;
            6'd47: c = 17'sd3084;
            6'd48: c = 17'sd2058;
            6'd49: c = 17'sd1029;
            6'd50: c = 17'sd0;
            6'd51: c = -17'sd1029;
            6'd52: c = -17'sd2058;
            6'd53: c = -17'sd3084;
            6'd54: c = -17'sd4107;
            6'd55: c = -17'sd5126;
            6'd56: c = -17'sd6140;
            6'd57: c = -17'sd7148;
            6'd58: c = -17'sd8149;
            6'd59: c = -17'sd9142;
            6'd60: c = -17'sd10126;
            6'd61: c = -17'sd11100;
            6'd62: c = -17'sd12063;
            6'd63: c = -17'sd13014;
            default: c = 17'sd0;
        endcase
        return c;
    endfunction

endpackage

// ===== src/qbt_div.sv =====
// pipelined restoring divider, one quotient bit per stage, several lanes
module qbt_div #(
    parameter int LANES = 6,
    parameter int DEN_W = 9,
    parameter int QUO_W = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic                                in_last,
    input  logic [LANES-1:0][DEN_W+QUO_W-1:0]   num,
    input  logic [LANES-1:0][DEN_W-1:0]         den,
    output logic                                out_valid,
    output logic                                out_last,
    output logic [LANES-1:0][QUO_W-1:0]         quo
);
    localparam int REM_W = DEN_W + QUO_W;

    logic                             v_reg    [QUO_W];
    logic                             last_reg [QUO_W];
    logic [LANES-1:0][QUO_W-1:0]      q_reg    [QUO_W];
    logic [LANES-1:0][REM_W-1:0]      rem_reg  [QUO_W];
    logic [LANES-1:0][DEN_W-1:0]      den_reg  [QUO_W];

    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        localparam int B = QUO_W - 1 - j;
        logic                         pv;
        logic                         plast;
        logic [LANES-1:0][REM_W-1:0]  prem;
        logic [LANES-1:0][DEN_W-1:0]  pden;
        logic [LANES-1:0][QUO_W-1:0]  pq;
        logic [LANES-1:0][REM_W-1:0]  rem_next;
        logic [LANES-1:0][QUO_W-1:0]  q_next;

        if (j == 0) begin : g_head
            assign pv    = in_valid;
            assign plast = in_last;
            assign prem  = num;
            assign pden  = den;
            assign pq    = '0;
        end else begin : g_body
            assign pv    = v_reg[j-1];
            assign plast = last_reg[j-1];
            assign prem  = rem_reg[j-1];
            assign pden  = den_reg[j-1];
            assign pq    = q_reg[j-1];
        end

        always_comb
        begin
            logic [REM_W-1:0] trial;
            for (int l = 0; l < LANES; l++)
            begin
                trial = REM_W'(pden[l]) << B;
                if (prem[l] >= trial)
                begin
                    rem_next[l] = prem[l] - trial;
                    q_next[l]   = pq[l] | (QUO_W'(1) << B);
                end
                else
                begin
                    rem_next[l] = prem[l];
                    q_next[l]   = pq[l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j] <= pv;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                last_reg[j] <= plast;
                q_reg[j]    <= q_next;
                rem_reg[j]  <= rem_next;
                den_reg[j]  <= pden;
            end
        end
    end

    assign out_valid = v_reg[QUO_W-1];
    assign out_last  = last_reg[QUO_W-1];
    assign quo       = q_reg[QUO_W-1];

endmodule

// ===== src/quadratic_bezier_tessellator_unit.sv =====
// top level of the quadratic bezier edge tessellator
// Takes one curved edge per transaction (start, end and control points in signed
// Q16.16, two packed RGBA colours) and returns n+1 points of the quadratic Bezier
// from the end point (t=0) to the start point (t=1), colours blended linearly, the
// last point flagged by is_last. The detail level n (1..DETAIL_LIMIT) is the largest k
// whose cosine threshold cos(k*pi/100) is not below the cosine of the angle between
// (start - control) and (start - end); a zero-length vector gives n = 1. The angle
// test runs through a classification pipeline of 6 + 3*ceil(log2(DETAIL_LIMIT+1))
// stages (vector scaling, dot products, then one binary search step per index bit,
// each step a cosine lookup, a split wide multiply and an exact compare). Points are
// issued one per cycle while the point channel does not stall, by an emitter into a
// point pipeline of 3 stages plus a 32-stage divider for the rounded division by n^2
// and by n. An edge occupies the emitter for its n+1 points (2 to DETAIL_LIMIT+1),
// which sets the sustained rate. Backpressure on the point channel stalls the point
// pipeline and emitter; a classified edge that meets a busy emitter holds the
// classification pipeline. No transaction is lost or repeated.
module quadratic_bezier_tessellator_unit #(
    parameter int DETAIL_LIMIT = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 seg_valid,
    output logic                 seg_ready,
    input  qbt_pkg::qbt_seg_t    seg,
    output logic                 point_valid,
    input  logic                 point_ready,
    output qbt_pkg::qbt_point_t  point
);
    import qbt_pkg::*;

    localparam int IDX_W = $clog2(DETAIL_LIMIT + 1);
    localparam int NSTEP = IDX_W;
    localparam int NSQ_W = 2 * IDX_W;
    localparam int DEN_W = NSQ_W + 1;
    localparam int NUM_W = DEN_W + QUO_W;
    localparam int PRD_W = COORD_W + NSQ_W + 1;
    localparam int SUM_W = PRD_W + 3;
    localparam int CPR_W = CH_W + IDX_W;
    localparam int LANES = 2 + NUM_CH;

    // context carried through the binary search on the detail level
    typedef struct packed {
        qbt_seg_t         seg;
        logic             force1;
        logic [61:0]      dsq;
        logic             dneg;
        logic             dzero;
        logic [61:0]      ab;
        logic [IDX_W-1:0] lo;
    } srch_t;

    // handshake and stall control
    logic front_adv;
    logic back_adv;
    logic front_last_v;
    logic em_load;
    logic em_done;

    // index of the top set bit, used to normalise a vector
    function automatic logic [5:0] top_one(input logic [32:0] v);
        logic [5:0] p;
        p = '0;
        for (int k = 0; k < 33; k++)
        begin
            if (v[k])
            begin
                p = 6'(k);
            end
        end
        return p;
    endfunction

    // ---------------------------------------------------------------
    // stage 0: edge vectors (start - control) and (start - end)
    // ---------------------------------------------------------------
    logic               f0_v_reg;
    qbt_seg_t           f0_seg_reg;
    logic signed [32:0] f0_ax_reg, f0_ay_reg, f0_bx_reg, f0_by_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f0_v_reg <= 1'b0;
        end
        else if (front_adv)
        begin
            f0_v_reg <= seg_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_adv)
        begin
            f0_seg_reg <= seg;
            f0_ax_reg  <= 33'(seg.start_x) - 33'(seg.ctrl_x);
            f0_ay_reg  <= 33'(seg.start_y) - 33'(seg.ctrl_y);
            f0_bx_reg  <= 33'(seg.start_x) - 33'(seg.end_x);
            f0_by_reg  <= 33'(seg.start_y) - 33'(seg.end_y);
        end
    end

    // ---------------------------------------------------------------
    // stage 1: magnitudes, signs and leading-one search
    // ---------------------------------------------------------------
    logic        f1_v_reg;
    qbt_seg_t    f1_seg_reg;
    logic        f1_force1_reg;
    logic [32:0] f1_ux_reg, f1_uy_reg, f1_vx_reg, f1_vy_reg;
    logic [3:0]  f1_neg_reg;
    logic [5:0]  f1_pa_reg, f1_pb_reg;
    logic [32:0] f1_ux_next, f1_uy_next, f1_vx_next, f1_vy_next;

    always_comb
    begin
        f1_ux_next = f0_ax_reg[32] ? 33'(-f0_ax_reg) : 33'(f0_ax_reg);
        f1_uy_next = f0_ay_reg[32] ? 33'(-f0_ay_reg) : 33'(f0_ay_reg);
        f1_vx_next = f0_bx_reg[32] ? 33'(-f0_bx_reg) : 33'(f0_bx_reg);
        f1_vy_next = f0_by_reg[32] ? 33'(-f0_by_reg) : 33'(f0_by_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
        end
        else if (front_adv)
        begin
            f1_v_reg <= f0_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_adv)
        begin
            f1_seg_reg    <= f0_seg_reg;
            f1_force1_reg <= (f0_ax_reg == '0 && f0_ay_reg == '0)
                          || (f0_bx_reg == '0 && f0_by_reg == '0);
            f1_ux_reg     <= f1_ux_next;
            f1_uy_reg     <= f1_uy_next;
            f1_vx_reg     <= f1_vx_next;
            f1_vy_reg     <= f1_vy_next;
            f1_neg_reg    <= {f0_by_reg[32], f0_bx_reg[32], f0_ay_reg[32], f0_ax_reg[32]};
            f1_pa_reg     <= top_one(f1_ux_next | f1_uy_next);
            f1_pb_reg     <= top_one(f1_vx_next | f1_vy_next);
        end
    end

    // ---------------------------------------------------------------
    // stage 2: scale each vector so its larger component sits in [2^14, 2^15)
    // ---------------------------------------------------------------
    logic               f2_v_reg;
    qbt_seg_t           f2_seg_reg;
    logic               f2_force1_reg;
    logic signed [15:0] f2_ax_reg, f2_ay_reg, f2_bx_reg, f2_by_reg;
    logic [14:0]        f2_mag [4];
    logic signed [15:0] f2_sv_next [4];

    always_comb
    begin
        if (f1_pa_reg >= 6'd14)
        begin
            f2_mag[0] = 15'(f1_ux_reg >> (f1_pa_reg - 6'd14));
            f2_mag[1] = 15'(f1_uy_reg >> (f1_pa_reg - 6'd14));
        end
        else
        begin
            f2_mag[0] = 15'(f1_ux_reg << (6'd14 - f1_pa_reg));
            f2_mag[1] = 15'(f1_uy_reg << (6'd14 - f1_pa_reg));
        end
        if (f1_pb_reg >= 6'd14)
        begin
            f2_mag[2] = 15'(f1_vx_reg >> (f1_pb_reg - 6'd14));
            f2_mag[3] = 15'(f1_vy_reg >> (f1_pb_reg - 6'd14));
        end
        else
        begin
            f2_mag[2] = 15'(f1_vx_reg << (6'd14 - f1_pb_reg));
            f2_mag[3] = 15'(f1_vy_reg << (6'd14 - f1_pb_reg));
        end
        for (int k = 0; k < 4; k++)
        begin
            f2_sv_next[k] = f1_neg_reg[k] ? -$signed({1'b0, f2_mag[k]})
                                          : $signed({1'b0, f2_mag[k]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f2_v_reg <= 1'b0;
        end
        else if (front_adv)
        begin
            f2_v_reg <= f1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_adv)
        begin
            f2_seg_reg    <= f1_seg_reg;
            f2_force1_reg <= f1_force1_reg;
            f2_ax_reg     <= f2_sv_next[0];
            f2_ay_reg     <= f2_sv_next[1];
            f2_bx_reg     <= f2_sv_next[2];
            f2_by_reg     <= f2_sv_next[3];
        end
    end

    // ---------------------------------------------------------------
    // stage 3: component-wise and square products
    // ---------------------------------------------------------------
    logic               f3_v_reg;
    qbt_seg_t           f3_seg_reg;
    logic               f3_force1_reg;
    logic signed [31:0] f3_dx_reg, f3_dy_reg;
    logic [29:0]        f3_aa1_reg, f3_aa2_reg, f3_bb1_reg, f3_bb2_reg;
    logic signed [31:0] f3_aa1_next, f3_aa2_next, f3_bb1_next, f3_bb2_next;

    always_comb
    begin
        f3_aa1_next = f2_ax_reg * f2_ax_reg;
        f3_aa2_next = f2_ay_reg * f2_ay_reg;
        f3_bb1_next = f2_bx_reg * f2_bx_reg;
        f3_bb2_next = f2_by_reg * f2_by_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f3_v_reg <= 1'b0;
        end
        else if (front_adv)
        begin
            f3_v_reg <= f2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_adv)
        begin
            f3_seg_reg    <= f2_seg_reg;
            f3_force1_reg <= f2_force1_reg;
            f3_dx_reg     <= f2_ax_reg * f2_bx_reg;
            f3_dy_reg     <= f2_ay_reg * f2_by_reg;
            f3_aa1_reg    <= f3_aa1_next[29:0];
            f3_aa2_reg    <= f3_aa2_next[29:0];
            f3_bb1_reg    <= f3_bb1_next[29:0];
            f3_bb2_reg    <= f3_bb2_next[29:0];
        end
    end

    // ---------------------------------------------------------------
    // stage 4: dot product and squared lengths
    // ---------------------------------------------------------------
    logic               f4_v_reg;
    qbt_seg_t           f4_seg_reg;
    logic               f4_force1_reg;
    logic signed [31:0] f4_dot_reg;
    logic [30:0]        f4_asq_reg, f4_bsq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f4_v_reg <= 1'b0;
        end
        else if (front_adv)
        begin
            f4_v_reg <= f3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_adv)
        begin
            f4_seg_reg    <= f3_seg_reg;
            f4_force1_reg <= f3_force1_reg;
            f4_dot_reg    <= f3_dx_reg + f3_dy_reg;
            f4_asq_reg    <= 31'(f3_aa1_reg) + 31'(f3_aa2_reg);
            f4_bsq_reg    <= 31'(f3_bb1_reg) + 31'(f3_bb2_reg);
        end
    end

    // ---------------------------------------------------------------
    // stage 5: dot squared and product of squared lengths
    // ---------------------------------------------------------------
    logic        f5_v_reg;
    srch_t       f5_ctx_reg;
    srch_t       f5_ctx_next;
    logic [30:0] f5_dmag;

    always_comb
    begin
        f5_dmag            = f4_dot_reg[31] ? 31'(-f4_dot_reg) : 31'(f4_dot_reg);
        f5_ctx_next.seg    = f4_seg_reg;
        f5_ctx_next.force1 = f4_force1_reg;
        f5_ctx_next.dsq    = 62'(f5_dmag) * 62'(f5_dmag);
        f5_ctx_next.dneg   = f4_dot_reg[31];
        f5_ctx_next.dzero  = (f4_dot_reg == '0);
        f5_ctx_next.ab     = 62'(f4_asq_reg) * 62'(f4_bsq_reg);
        f5_ctx_next.lo     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f5_v_reg <= 1'b0;
        end
        else if (front_adv)
        begin
            f5_v_reg <= f4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_adv)
        begin
            f5_ctx_reg <= f5_ctx_next;
        end
    end

    // ---------------------------------------------------------------
    // binary search for the detail level, one index bit per step
    // step stages: cosine lookup and square, split multiply, compare
    // ---------------------------------------------------------------
    logic             sa_v_reg    [NSTEP];
    srch_t            sa_ctx_reg  [NSTEP];
    logic [IDX_W-1:0] sa_cand_reg [NSTEP];
    logic             sa_ok_reg   [NSTEP];
    logic [30:0]      sa_c2_reg   [NSTEP];
    logic             sa_cneg_reg [NSTEP];
    logic             sa_czero_reg[NSTEP];

    logic             sb_v_reg    [NSTEP];
    srch_t            sb_ctx_reg  [NSTEP];
    logic [IDX_W-1:0] sb_cand_reg [NSTEP];
    logic             sb_ok_reg   [NSTEP];
    logic             sb_cneg_reg [NSTEP];
    logic             sb_czero_reg[NSTEP];
    logic [61:0]      sb_ph_reg   [NSTEP];
    logic [61:0]      sb_pl_reg   [NSTEP];

    logic             sc_v_reg    [NSTEP];
    srch_t            sc_ctx_reg  [NSTEP];

    for (genvar s = 0; s < NSTEP; s++) begin : g_step
        localparam int B = NSTEP - 1 - s;
        srch_t              in_ctx;
        logic               in_v;
        logic [IDX_W-1:0]   cand;
        logic signed [16:0] cv;
        logic signed [33:0] csq;
        logic [93:0]        lhs;
        logic [93:0]        rhs;
        logic               pass;
        srch_t              sc_ctx_next;

        if (s == 0) begin : g_first
            assign in_ctx = f5_ctx_reg;
            assign in_v   = f5_v_reg;
        end else begin : g_chain
            assign in_ctx = sc_ctx_reg[s-1];
            assign in_v   = sc_v_reg[s-1];
        end

        always_comb
        begin
            cand = in_ctx.lo | (IDX_W'(1) << B);
            cv   = cos_q15(TAB_IDX_W'(cand));
            csq  = cv * cv;
        end

        // exact test of cos(angle) <= c / 2^15 on d^2 * 2^30 against c^2 * a * b
        always_comb
        begin
            lhs = 94'(sb_ctx_reg[s].dsq) << 30;
            rhs = (94'(sb_ph_reg[s]) << 31) + 94'(sb_pl_reg[s]);
            if (sb_czero_reg[s])
            begin
                pass = sb_ctx_reg[s].dneg || sb_ctx_reg[s].dzero;
            end
            else if (!sb_cneg_reg[s])
            begin
                pass = sb_ctx_reg[s].dneg || sb_ctx_reg[s].dzero || (lhs <= rhs);
            end
            else
            begin
                pass = sb_ctx_reg[s].dneg && (lhs >= rhs);
            end
            sc_ctx_next = sb_ctx_reg[s];
            if (sb_ok_reg[s] && pass)
            begin
                sc_ctx_next.lo = sb_cand_reg[s];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sa_v_reg[s] <= 1'b0;
                sb_v_reg[s] <= 1'b0;
                sc_v_reg[s] <= 1'b0;
            end
            else if (front_adv)
            begin
                sa_v_reg[s] <= in_v;
                sb_v_reg[s] <= sa_v_reg[s];
                sc_v_reg[s] <= sb_v_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (front_adv)
            begin
                sa_ctx_reg[s]   <= in_ctx;
                sa_cand_reg[s]  <= cand;
                sa_ok_reg[s]    <= (cand <= IDX_W'(DETAIL_LIMIT));
                sa_c2_reg[s]    <= csq[30:0];
                sa_cneg_reg[s]  <= cv[16];
                sa_czero_reg[s] <= (cv == '0);

                sb_ctx_reg[s]   <= sa_ctx_reg[s];
                sb_cand_reg[s]  <= sa_cand_reg[s];
                sb_ok_reg[s]    <= sa_ok_reg[s];
                sb_cneg_reg[s]  <= sa_cneg_reg[s];
                sb_czero_reg[s] <= sa_czero_reg[s];
                sb_ph_reg[s]    <= 62'(sa_c2_reg[s]) * 62'(sa_ctx_reg[s].ab[61:31]);
                sb_pl_reg[s]    <= 62'(sa_c2_reg[s]) * 62'(sa_ctx_reg[s].ab[30:0]);

                sc_ctx_reg[s]   <= sc_ctx_next;
            end
        end
    end

    // ---------------------------------------------------------------
    // emitter: walks i = 0..n for the edge it holds
    // ---------------------------------------------------------------
    srch_t            fin_ctx;
    logic [IDX_W-1:0] fin_n;

    logic             em_valid_reg, em_valid_next;
    qbt_seg_t         em_seg_reg, em_seg_next;
    logic [IDX_W-1:0] em_n_reg, em_n_next;
    logic [IDX_W-1:0] em_i_reg, em_i_next;

    logic             div_valid;
    logic             div_last;
    logic [LANES-1:0][QUO_W-1:0] div_quo;

    assign front_last_v = sc_v_reg[NSTEP-1];
    assign fin_ctx      = sc_ctx_reg[NSTEP-1];
    assign fin_n        = (fin_ctx.force1 || fin_ctx.lo == '0) ? IDX_W'(1) : fin_ctx.lo;

    assign back_adv  = !div_valid || point_ready;
    assign em_done   = em_valid_reg && (em_i_reg == em_n_reg);
    assign em_load   = front_last_v && (!em_valid_reg || (em_done && back_adv));
    assign front_adv = !front_last_v || em_load;
    assign seg_ready = front_adv;

    always_comb
    begin
        em_valid_next = em_valid_reg;
        em_seg_next   = em_seg_reg;
        em_n_next     = em_n_reg;
        em_i_next     = em_i_reg;
        if (em_load)
        begin
            em_valid_next = 1'b1;
            em_seg_next   = fin_ctx.seg;
            em_n_next     = fin_n;
            em_i_next     = '0;
        end
        else if (back_adv && em_valid_reg)
        begin
            if (em_done)
            begin
                em_valid_next = 1'b0;
            end
            else
            begin
                em_i_next = em_i_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_valid_reg <= 1'b0;
            em_n_reg     <= '0;
            em_i_reg     <= '0;
        end
        else
        begin
            em_valid_reg <= em_valid_next;
            em_n_reg     <= em_n_next;
            em_i_reg     <= em_i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        em_seg_reg <= em_seg_next;
    end

    // ---------------------------------------------------------------
    // point stage 1: bernstein weights i^2, i*(n-i), (n-i)^2 and n^2
    // ---------------------------------------------------------------
    logic             p1_v_reg;
    logic             p1_last_reg;
    qbt_seg_t         p1_seg_reg;
    logic [IDX_W-1:0] p1_i_reg, p1_w_reg, p1_n_reg;
    logic [NSQ_W-1:0] p1_ii_reg, p1_iw_reg, p1_ww_reg, p1_nsq_reg;
    logic [IDX_W-1:0] p1_w_next;

    assign p1_w_next = em_n_reg - em_i_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
        end
        else if (back_adv)
        begin
            p1_v_reg <= em_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_adv)
        begin
            p1_last_reg <= em_done;
            p1_seg_reg  <= em_seg_reg;
            p1_i_reg    <= em_i_reg;
            p1_w_reg    <= p1_w_next;
            p1_n_reg    <= em_n_reg;
            p1_ii_reg   <= NSQ_W'(em_i_reg) * NSQ_W'(em_i_reg);
            p1_iw_reg   <= NSQ_W'(em_i_reg) * NSQ_W'(p1_w_next);
            p1_ww_reg   <= NSQ_W'(p1_w_next) * NSQ_W'(p1_w_next);
            p1_nsq_reg  <= NSQ_W'(em_n_reg) * NSQ_W'(em_n_reg);
        end
    end

    // ---------------------------------------------------------------
    // point stage 2: weighted products of points and colour channels
    // ---------------------------------------------------------------
    logic                    p2_v_reg;
    logic                    p2_last_reg;
    logic [IDX_W-1:0]        p2_n_reg;
    logic [NSQ_W-1:0]        p2_nsq_reg;
    logic signed [PRD_W-1:0] p2_sx_reg, p2_cx_reg, p2_ex_reg;
    logic signed [PRD_W-1:0] p2_sy_reg, p2_cy_reg, p2_ey_reg;
    logic [CPR_W-1:0]        p2_cs_reg [NUM_CH];
    logic [CPR_W-1:0]        p2_ce_reg [NUM_CH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_v_reg <= 1'b0;
        end
        else if (back_adv)
        begin
            p2_v_reg <= p1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_adv)
        begin
            p2_last_reg <= p1_last_reg;
            p2_n_reg    <= p1_n_reg;
            p2_nsq_reg  <= p1_nsq_reg;
            p2_sx_reg   <= p1_seg_reg.start_x * $signed({1'b0, p1_ii_reg});
            p2_cx_reg   <= p1_seg_reg.ctrl_x  * $signed({1'b0, p1_iw_reg});
            p2_ex_reg   <= p1_seg_reg.end_x   * $signed({1'b0, p1_ww_reg});
            p2_sy_reg   <= p1_seg_reg.start_y * $signed({1'b0, p1_ii_reg});
            p2_cy_reg   <= p1_seg_reg.ctrl_y  * $signed({1'b0, p1_iw_reg});
            p2_ey_reg   <= p1_seg_reg.end_y   * $signed({1'b0, p1_ww_reg});
            for (int k = 0; k < NUM_CH; k++)
            begin
                p2_cs_reg[k] <= CPR_W'(p1_seg_reg.start_colour[CH_W*k +: CH_W])
                              * CPR_W'(p1_i_reg);
                p2_ce_reg[k] <= CPR_W'(p1_seg_reg.end_colour[CH_W*k +: CH_W])
                              * CPR_W'(p1_w_reg);
            end
        end
    end

    // ---------------------------------------------------------------
    // point stage 3: rounding numerators, offset so the division is unsigned
    // x: (2*num + n^2 + n^2 * 2^32) / (2*n^2), then 2^31 taken off the quotient
    // colour: (2*(s*i + e*(n-i)) + n) / (2*n)
    // ---------------------------------------------------------------
    logic                         p3_v_reg;
    logic                         p3_last_reg;
    logic [LANES-1:0][NUM_W-1:0]  p3_num_reg;
    logic [LANES-1:0][DEN_W-1:0]  p3_den_reg;
    logic [LANES-1:0][NUM_W-1:0]  p3_num_next;
    logic [LANES-1:0][DEN_W-1:0]  p3_den_next;
    logic signed [SUM_W-1:0]      p3_tx, p3_ty, p3_off;

    always_comb
    begin
        p3_off = SUM_W'({1'b0, p2_nsq_reg}) + (SUM_W'({1'b0, p2_nsq_reg}) << 32);
        p3_tx  = SUM_W'(p2_sx_reg) + (SUM_W'(p2_cx_reg) <<< 1) + SUM_W'(p2_ex_reg);
        p3_ty  = SUM_W'(p2_sy_reg) + (SUM_W'(p2_cy_reg) <<< 1) + SUM_W'(p2_ey_reg);
        p3_num_next[0] = NUM_W'((p3_tx <<< 1) + p3_off);
        p3_num_next[1] = NUM_W'((p3_ty <<< 1) + p3_off);
        p3_den_next[0] = DEN_W'({p2_nsq_reg, 1'b0});
        p3_den_next[1] = DEN_W'({p2_nsq_reg, 1'b0});
        for (int k = 0; k < NUM_CH; k++)
        begin
            p3_num_next[2+k] = (NUM_W'(p2_cs_reg[k]) + NUM_W'(p2_ce_reg[k])) * NUM_W'(2)
                             + NUM_W'(p2_n_reg);
            p3_den_next[2+k] = DEN_W'({p2_n_reg, 1'b0});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p3_v_reg <= 1'b0;
        end
        else if (back_adv)
        begin
            p3_v_reg <= p2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_adv)
        begin
            p3_last_reg <= p2_last_reg;
            p3_num_reg  <= p3_num_next;
            p3_den_reg  <= p3_den_next;
        end
    end

    // ---------------------------------------------------------------
    // divider: its last stage is the output register
    // ---------------------------------------------------------------
    qbt_div #(
        .LANES (LANES),
        .DEN_W (DEN_W),
        .QUO_W (QUO_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (back_adv),
        .in_valid  (p3_v_reg),
        .in_last   (p3_last_reg),
        .num       (p3_num_reg),
        .den       (p3_den_reg),
        .out_valid (div_valid),
        .out_last  (div_last),
        .quo       (div_quo)
    );

    // removing the 2^31 offset is a flip of the top bit
    always_comb
    begin
        point.point_x = {~div_quo[0][QUO_W-1], div_quo[0][QUO_W-2:0]};
        point.point_y = {~div_quo[1][QUO_W-1], div_quo[1][QUO_W-2:0]};
        for (int k = 0; k < NUM_CH; k++)
        begin
            point.point_colour[CH_W*k +: CH_W] = div_quo[2+k][CH_W-1:0];
        end
        point.is_last = div_last;
    end

    assign point_valid = div_valid;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
`include "quadratic_bezier_tessellator_unit_assert.svh"

    `QBT_ASSERT_NOW(a_em_index, em_valid_reg, (em_i_reg <= em_n_reg) && (em_n_reg != '0), "emitter index beyond detail level")
    `QBT_ASSERT_NEXT(a_em_step, em_valid_reg && back_adv && !em_done, em_valid_reg && (em_i_reg == IDX_W'($past(em_i_reg) + 1'b1)), "emitter skipped or repeated a point")
    `QBT_ASSERT_NEXT(a_front_hold, front_last_v && !em_load, front_last_v && $stable(fin_n), "classified edge lost while emitter busy")

endmodule
